// File: hw/rtl/mm_pkg.sv
// Shared types and constants for the matrix multiply block.
package mm_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int ELEM_WIDTH_DEF = 16;

	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CMD_W     = 2;
	localparam int IDX_W     = 3;
	localparam int IN_ELEM_W = 16;
	localparam int OUT_W     = 36;

	localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(8);

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_A  = 2'd0,
		CMD_LOAD_B  = 2'd1,
		CMD_COMPUTE = 2'd2
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROWS_A  = 2'd0,
		CFG_INNER   = 2'd1,
		CFG_COLS_B  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} state_t;

endpackage

// File: hw/rtl/matrix_multiply.sv
// Matrix multiply top level: element stores, inner-product sequencer, result register.
// Loads: one transfer per cycle while idle, no result.
// Compute: each result element takes one store read per inner step, then read, multiply
// and accumulate stages, and then waits for as long as the result side stalls.
// Reset sets the size registers to 8 and clears control state; the stores are undefined.
module matrix_multiply #(
	parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
	parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]      cfg_data,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [mm_pkg::CMD_W-1:0]      cmd,
	input  logic [mm_pkg::IDX_W-1:0]      row_index,
	input  logic [mm_pkg::IDX_W-1:0]      col_index,
	input  logic signed [mm_pkg::IN_ELEM_W-1:0] elem_value,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [mm_pkg::IDX_W-1:0]      out_row,
	output logic [mm_pkg::IDX_W-1:0]      out_col,
	output logic signed [mm_pkg::OUT_W-1:0] out_value,
	output logic                          is_last
);

	localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW    = 2 * ELEM_WIDTH;
	localparam int CW    = mm_pkg::CFG_W;
	localparam logic [CW-1:0] DIM_MAX = CW'(MAX_DIM);

	// size registers
	logic [CW-1:0] rows_a_q, inner_q, cols_b_q;
	logic [CW-1:0] nr, nk, nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= mm_pkg::DIM_RESET;
			inner_q  <= mm_pkg::DIM_RESET;
			cols_b_q <= mm_pkg::DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data;
				mm_pkg::CFG_INNER:  inner_q  <= cfg_data;
				mm_pkg::CFG_COLS_B: cols_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		nr = (rows_a_q == '0) ? CW'(1) : ((rows_a_q > DIM_MAX) ? DIM_MAX : rows_a_q);
		nk = (inner_q  == '0) ? CW'(1) : ((inner_q  > DIM_MAX) ? DIM_MAX : inner_q);
		nc = (cols_b_q == '0) ? CW'(1) : ((cols_b_q > DIM_MAX) ? DIM_MAX : cols_b_q);
	end

	// sequencer
	mm_pkg::state_t state_q, state_nxt;
	logic [DW-1:0]  i_q, j_q, p_q;
	logic           res_valid_q;
	logic           v_s1, first_s1, last_s1;
	logic           v_s2, first_s2, last_s2;

	logic item_xfer, res_xfer;
	logic p_last, j_last, i_last, elem_last;
	logic start, issue, advance;

	assign item_xfer = item_valid && !item_stall;
	assign res_xfer  = res_valid_q && !res_stall;
	assign p_last    = (CW'(p_q) == nk - CW'(1));
	assign j_last    = (CW'(j_q) == nc - CW'(1));
	assign i_last    = (CW'(i_q) == nr - CW'(1));
	assign elem_last = i_last && j_last;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mm_pkg::ST_IDLE:
				if (item_xfer && cmd == mm_pkg::CMD_COMPUTE) state_nxt = mm_pkg::ST_RUN;
			mm_pkg::ST_RUN:
				if (p_last) state_nxt = mm_pkg::ST_WAIT;
			mm_pkg::ST_WAIT:
				if (res_xfer) state_nxt = elem_last ? mm_pkg::ST_IDLE : mm_pkg::ST_RUN;
			default: state_nxt = mm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall = 1'b1;
		start      = 1'b0;
		issue      = 1'b0;
		advance    = 1'b0;
		unique case (state_q)
			mm_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				start      = item_valid && cmd == mm_pkg::CMD_COMPUTE;
			end
			mm_pkg::ST_RUN:  issue   = 1'b1;
			mm_pkg::ST_WAIT: advance = res_xfer && !elem_last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mm_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
		end else begin
			state_q <= state_nxt;
			if (start) begin
				i_q <= '0;
				j_q <= '0;
				p_q <= '0;
			end else if (issue) begin
				p_q <= p_last ? '0 : p_q + DW'(1);
			end else if (advance) begin
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + DW'(1);
				end else begin
					j_q <= j_q + DW'(1);
				end
			end
		end
	end

	// element stores
	logic [ELEM_WIDTH-1:0] a_mem [DEPTH];
	logic [ELEM_WIDTH-1:0] b_mem [DEPTH];
	logic [ELEM_WIDTH-1:0] wr_val;
	logic [AW-1:0]         wr_addr, rd_a_addr, rd_b_addr;
	logic                  wr_ok;
	logic signed [ELEM_WIDTH-1:0] rd_a_s1, rd_b_s1;

	assign wr_val    = ELEM_WIDTH'($unsigned(elem_value));
	assign wr_addr   = AW'(int'(row_index) * MAX_DIM + int'(col_index));
	assign wr_ok     = item_xfer && (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);
	assign rd_a_addr = AW'(int'(i_q) * MAX_DIM + int'(p_q));
	assign rd_b_addr = AW'(int'(p_q) * MAX_DIM + int'(j_q));

	always_ff @(posedge clk) begin
		if (wr_ok && cmd == mm_pkg::CMD_LOAD_A) a_mem[wr_addr] <= wr_val;
		if (wr_ok && cmd == mm_pkg::CMD_LOAD_B) b_mem[wr_addr] <= wr_val;
		rd_a_s1 <= a_mem[rd_a_addr];
		rd_b_s1 <= b_mem[rd_b_addr];
	end

	// multiply and accumulate pipeline
	logic signed [PW-1:0]   prod_s2;
	logic signed [mm_pkg::OUT_W-1:0] acc_q, prod_ext, sum_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= (p_q == '0);
		last_s1  <= p_last;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= rd_a_s1 * rd_b_s1;
	end

	assign prod_ext = mm_pkg::OUT_W'(prod_s2);
	assign sum_nxt  = first_s2 ? prod_ext : acc_q + prod_ext;

	always_ff @(posedge clk) begin
		if (v_s2) acc_q <= sum_nxt;
	end

	// result register; the sequencer waits for its transfer before the next element
	logic [mm_pkg::IDX_W-1:0]        out_row_q, out_col_q;
	logic signed [mm_pkg::OUT_W-1:0] out_value_q;
	logic                            is_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (v_s2 && last_s2) begin
			res_valid_q <= 1'b1;
		end else if (res_xfer) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && last_s2) begin
			out_row_q   <= mm_pkg::IDX_W'(i_q);
			out_col_q   <= mm_pkg::IDX_W'(j_q);
			out_value_q <= sum_nxt;
			is_last_q   <= elem_last;
		end
	end

	assign res_valid = res_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_value = out_value_q;
	assign is_last   = is_last_q;

endmodule
